FILE: rtl/core/fde_pkg.sv
// Package for the FAT16 directory entry decoder: entry layout constants,
// character codes, the name sequencer state type and the shared structs.
// No dependencies.
package fde_pkg;

  localparam int ENTRY_BYTES = 32;
  localparam int NAME_CHARS  = 8;
  localparam int EXT_CHARS   = 3;
  localparam int NAME_BYTES  = NAME_CHARS + EXT_CHARS;
  localparam int POS_W       = $clog2(ENTRY_BYTES);
  localparam int IDX_W       = $clog2(NAME_BYTES + 1);

  // Byte offsets inside one directory entry.
  localparam logic [POS_W-1:0] POS_ATTR     = POS_W'(11);
  localparam logic [POS_W-1:0] POS_TIME_LO  = POS_W'(22);
  localparam logic [POS_W-1:0] POS_TIME_HI  = POS_W'(23);
  localparam logic [POS_W-1:0] POS_DATE_LO  = POS_W'(24);
  localparam logic [POS_W-1:0] POS_DATE_HI  = POS_W'(25);
  localparam logic [POS_W-1:0] POS_CLUS_LO  = POS_W'(26);
  localparam logic [POS_W-1:0] POS_CLUS_HI  = POS_W'(27);
  localparam logic [POS_W-1:0] POS_SIZE_0   = POS_W'(28);
  localparam logic [POS_W-1:0] POS_SIZE_1   = POS_W'(29);
  localparam logic [POS_W-1:0] POS_SIZE_2   = POS_W'(30);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(ENTRY_BYTES - 1);

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_DELETED = 8'hE5;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_KANJI   = 8'h05;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] ATTR_SUBDIR  = 8'h10;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_NAME,
    SEQ_DOT,
    SEQ_EXT,
    SEQ_PARENT2
  } seq_state_t;

  // Classification of the stored entry, handed to the name sequencer.
  typedef struct packed {
    logic subdir;
    logic unused;
    logic deleted;
    logic root;
    logic parent;
  } entry_info_t;

  // One character produced by the sequencer.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       present;
    logic       last;
  } emit_t;

endpackage

FILE: rtl/core/fde_name_seq.sv
// Name sequencer of the FAT16 directory entry decoder: walks the stored
// 8.3 name one byte per cycle while slot_free, with a single byte select
// and per-byte space flags. Depends on fde_pkg.
module fde_name_seq (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic                                    slot_free,
  input  fde_pkg::entry_info_t                    info,
  input  logic [fde_pkg::NAME_BYTES-1:0][7:0]     name_bytes,
  output logic                                    busy,
  output fde_pkg::emit_t                          emit
);
  import fde_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  next_idx;
  logic [NAME_BYTES:0] space_mask;
  logic [7:0]        cur_byte;
  logic [7:0]        cur_char;
  logic              name_end;

  // One flag per name byte; the extra top bit ends the extension.
  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      space_mask[k] = (name_bytes[k] == CHAR_SPACE);
    end
    space_mask[NAME_BYTES] = 1'b1;
  end

  assign next_idx = idx_r + IDX_W'(1);
  assign cur_byte = name_bytes[idx_r];
  assign cur_char = ((idx_r == '0) && (cur_byte == CHAR_KANJI)) ? CHAR_DELETED : cur_byte;
  assign name_end = (idx_r == IDX_W'(NAME_CHARS - 1)) || space_mask[next_idx];
  assign busy     = (state_r != SEQ_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    emit      = '0;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_START;
        end
      end
      SEQ_START: begin
        if (slot_free) begin
          if (info.unused || info.deleted) begin
            emit      = '{valid: 1'b1, ch: CHAR_NUL, present: 1'b0, last: 1'b1};
            state_nxt = SEQ_IDLE;
          end else if (info.root) begin
            emit      = '{valid: 1'b1, ch: CHAR_SLASH, present: 1'b1, last: 1'b1};
            state_nxt = SEQ_IDLE;
          end else if (info.parent) begin
            emit      = '{valid: 1'b1, ch: CHAR_DOT, present: 1'b1, last: 1'b0};
            state_nxt = SEQ_PARENT2;
          end else if (space_mask[0]) begin
            if (info.subdir) begin
              emit      = '{valid: 1'b1, ch: CHAR_NUL, present: 1'b0, last: 1'b1};
              state_nxt = SEQ_IDLE;
            end else begin
              state_nxt = SEQ_DOT;
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = SEQ_NAME;
          end
        end
      end
      SEQ_NAME: begin
        if (slot_free) begin
          emit = '{valid: 1'b1, ch: cur_char, present: 1'b1, last: name_end && info.subdir};
          if (name_end) begin
            state_nxt = info.subdir ? SEQ_IDLE : SEQ_DOT;
          end else begin
            idx_nxt = next_idx;
          end
        end
      end
      SEQ_DOT: begin
        if (slot_free) begin
          emit = '{valid: 1'b1, ch: CHAR_DOT, present: 1'b1, last: space_mask[NAME_CHARS]};
          if (space_mask[NAME_CHARS]) begin
            state_nxt = SEQ_IDLE;
          end else begin
            idx_nxt   = IDX_W'(NAME_CHARS);
            state_nxt = SEQ_EXT;
          end
        end
      end
      SEQ_EXT: begin
        if (slot_free) begin
          emit = '{valid: 1'b1, ch: cur_byte, present: 1'b1, last: space_mask[next_idx]};
          if (space_mask[next_idx]) begin
            state_nxt = SEQ_IDLE;
          end else begin
            idx_nxt = next_idx;
          end
        end
      end
      SEQ_PARENT2: begin
        if (slot_free) begin
          emit      = '{valid: 1'b1, ch: CHAR_DOT, present: 1'b1, last: 1'b1};
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/fat_dir_entry_decoder_core.sv
// Top level of the FAT16 8.3 directory entry decoder: byte collection,
// field stores, entry classification and the output register.
// Depends on fde_pkg and fde_name_seq.
//
// Usage: the raw bytes of one 32-byte FAT16 directory entry arrive on the
// in_ stream, one byte per transaction, in entry order. The block keeps the
// eleven name bytes and the little-endian attribute, time, date, cluster
// and size fields. After the last byte of an entry it produces the display
// name on the out_ stream, one character per transaction, with out_tlast on
// the final one. Every output transaction also carries the decoded fields
// and the four entry flags. Unused or deleted entries, and entries whose
// rules yield no characters, give a single transaction with out_tuser low.
//
// Timing: the 32 entry bytes are taken one per cycle while the sequencer
// is idle. After the last byte the name sequencer takes a decision step,
// then loads the characters in order whenever the output register is free,
// with the first character of a special name (empty, root or parent)
// leaving in the decision step; a name has at most 12 characters. The
// sequencer steps through the name with one shared byte select and a
// per-byte space mask, and in_tready stays low from the last byte until
// the final character has been loaded into the output register. A stalled
// receiver holds the output register and the sequencer waits; the next
// entry may be collected while the final character still waits to be taken.
// Reset clears the byte counter, the sequencer and the output valid flag.
module fat_dir_entry_decoder_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] entry_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] name_char, [15:8] attributes, [31:16] time_raw, [47:32] date_raw,
  // [63:48] start_cluster, [95:64] file_size, [96] is_unused,
  // [97] is_deleted, [98] is_root, [99] is_parent, [103:100] zero
  output logic [103:0] out_tdata,
  output logic         out_tuser,   // [0] name_present
  output logic         out_tlast    // last_char
);
  import fde_pkg::*;

  logic [POS_W-1:0]            pos_r;
  logic [NAME_BYTES-1:0][7:0]  name_r;
  logic [7:0]                  attr_r;
  logic [15:0]                 time_r;
  logic [15:0]                 date_r;
  logic [15:0]                 clus_r;
  logic [31:0]                 size_r;

  logic                        in_fire;
  logic                        seq_busy;
  logic                        slot_free;
  entry_info_t                 info;
  emit_t                       emit;

  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_char_r;
  logic                        out_present_r;
  logic                        out_last_r;
  logic [7:0]                  out_attr_r;
  logic [15:0]                 out_time_r;
  logic [15:0]                 out_date_r;
  logic [15:0]                 out_clus_r;
  logic [31:0]                 out_size_r;
  logic [3:0]                  out_flags_r;

  assign in_tready = !seq_busy;
  assign in_fire   = in_tvalid && in_tready;

  // Byte position within the entry; wraps after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // Field stores, written at the byte offsets of the entry layout.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (pos_r < POS_W'(NAME_BYTES)) begin
        name_r[pos_r[IDX_W-1:0]] <= in_tdata;
      end else if (pos_r == POS_ATTR) begin
        attr_r <= in_tdata;
      end else if ((pos_r == POS_TIME_LO) || (pos_r == POS_TIME_HI)) begin
        time_r[{pos_r[0], 3'b000} +: 8] <= in_tdata;
      end else if ((pos_r == POS_DATE_LO) || (pos_r == POS_DATE_HI)) begin
        date_r[{pos_r[0], 3'b000} +: 8] <= in_tdata;
      end else if ((pos_r == POS_CLUS_LO) || (pos_r == POS_CLUS_HI)) begin
        clus_r[{pos_r[0], 3'b000} +: 8] <= in_tdata;
      end else if ((pos_r == POS_SIZE_0) || (pos_r == POS_SIZE_1) ||
                   (pos_r == POS_SIZE_2) || (pos_r == POS_LAST)) begin
        size_r[{pos_r[1:0], 3'b000} +: 8] <= in_tdata;
      end
    end
  end

  // Entry classification from the stored first name bytes, attribute and cluster.
  assign info.subdir  = (attr_r & ATTR_SUBDIR) != 8'h00;
  assign info.unused  = (name_r[0] == CHAR_NUL);
  assign info.deleted = (name_r[0] == CHAR_DELETED);
  assign info.root    = (name_r[0] == CHAR_DOT) && (clus_r == 16'h0000);
  assign info.parent  = (name_r[0] == CHAR_DOT) && (name_r[1] == CHAR_DOT);

  assign slot_free = !out_valid_r || out_tready;

  fde_name_seq u_name_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire && (pos_r == POS_LAST)),
    .slot_free  (slot_free),
    .info       (info),
    .name_bytes (name_r),
    .busy       (seq_busy),
    .emit       (emit)
  );

  // Output register; the entry fields are copied with every character so
  // that the next entry can be collected while the final one waits.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_char_r    <= emit.ch;
      out_present_r <= emit.present;
      out_last_r    <= emit.last;
      out_attr_r    <= attr_r;
      out_time_r    <= time_r;
      out_date_r    <= date_r;
      out_clus_r    <= clus_r;
      out_size_r    <= size_r;
      out_flags_r   <= {info.parent, info.root, info.deleted, info.unused};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_present_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_flags_r, out_size_r, out_clus_r, out_date_r,
                       out_time_r, out_attr_r, out_char_r};

  // While the sequencer runs, the byte counter has wrapped to the entry start.
  a_busy_at_entry_start: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (pos_r == '0))
    else $error("sequencer busy while an entry is half collected");

  // The last byte of an entry always hands control to the sequencer.
  a_last_byte_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (pos_r == POS_LAST)) |=> !in_tready)
    else $error("input still ready after the last entry byte");

  // An empty-name result is a run of exactly one transaction.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && (out_tdata[7:0] == CHAR_NUL)))
    else $error("empty-name result not marked last or carries a character");

  // A character is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !emit.valid)
    else $error("sequencer loaded the output register while it was stalled");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fat_dir_entry_decoder_core: streams FAT16
// directory entries in, predicts each display-name run and checks every output.
// Depends on fde_pkg and the decoder RTL.
module tb;
  import fde_pkg::*;

  // Clock and reset. Reset is synchronous and held low from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // Stimulus side. Every input is known from time zero.
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;      // [7:0] entry_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [7:0] name_char, [15:8] attributes, [31:16] time_raw, [47:32] date_raw,
  // [63:48] start_cluster, [95:64] file_size, [96] is_unused,
  // [97] is_deleted, [98] is_root, [99] is_parent, [103:100] zero
  logic [103:0] out_tdata;
  logic         out_tuser;             // [0] name_present
  logic         out_tlast;             // last_char

  fat_dir_entry_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // One expected output transaction: a single display-name character with the
  // decoded fields and flags of its entry.
  typedef struct {
    logic [7:0]  ch;
    logic        present;
    logic        last;
    logic [7:0]  attr;
    logic [15:0] tm;
    logic [15:0] dt;
    logic [15:0] clus;
    logic [31:0] fsize;
    logic        unused;
    logic        deleted;
    logic        root;
    logic        parent;
  } name_xact_t;

  name_xact_t expected_names[$];

  // Shadow copy of the decoder's entry state, updated on every accepted byte.
  logic [4:0]  shadow_pos = '0;
  logic [7:0]  shadow_name[NAME_BYTES];
  logic [7:0]  shadow_attr;
  logic [15:0] shadow_time;
  logic [15:0] shadow_date;
  logic [15:0] shadow_clus;
  logic [31:0] shadow_size;

  // The entry that the current test is about to stream in.
  logic [7:0] entry_buf[ENTRY_BYTES];

  // Idling controls: percentage chance of a gap before each input byte, of
  // a stall on the output side, and a one-shot output hold-off in cycles.
  int in_gap_pct    = 20;
  int out_stall_pct = 20;
  int hold_cycles   = 0;

  int mismatches     = 0;
  int bytes_sent     = 0;
  int entries_done   = 0;
  int xacts_checked  = 0;
  int empty_checked  = 0;

  // Gap lengths are mostly short with an occasional long one.
  function automatic int draw_idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // Predictor: fold one accepted byte into the shadow state. On the last
  // byte of an entry, work out the display name and queue one expected
  // transaction per character, or a single empty one when there are none.
  task automatic absorb_entry_byte(input logic [7:0] b);
    logic [7:0] chars[NAME_BYTES + 1];
    int         n;
    int         first;
    logic       stop;
    logic       f_unused, f_deleted, f_root, f_parent;
    logic       at_last;
    name_xact_t x;

    if (shadow_pos < NAME_BYTES) shadow_name[shadow_pos] = b;
    else if (shadow_pos == POS_ATTR) shadow_attr = b;
    else if (shadow_pos == POS_TIME_LO) shadow_time[7:0] = b;
    else if (shadow_pos == POS_TIME_HI) shadow_time[15:8] = b;
    else if (shadow_pos == POS_DATE_LO) shadow_date[7:0] = b;
    else if (shadow_pos == POS_DATE_HI) shadow_date[15:8] = b;
    else if (shadow_pos == POS_CLUS_LO) shadow_clus[7:0] = b;
    else if (shadow_pos == POS_CLUS_HI) shadow_clus[15:8] = b;
    else if (shadow_pos == POS_SIZE_0) shadow_size[7:0] = b;
    else if (shadow_pos == POS_SIZE_1) shadow_size[15:8] = b;
    else if (shadow_pos == POS_SIZE_2) shadow_size[23:16] = b;
    else if (shadow_pos == POS_LAST) shadow_size[31:24] = b;

    at_last = (shadow_pos == POS_LAST);
    shadow_pos = shadow_pos + 5'd1;
    if (!at_last) return;

    f_unused  = (shadow_name[0] == CHAR_NUL);
    f_deleted = (shadow_name[0] == CHAR_DELETED);
    f_root    = (shadow_name[0] == CHAR_DOT) && (shadow_clus == 16'h0000);
    f_parent  = (shadow_name[0] == CHAR_DOT) && (shadow_name[1] == CHAR_DOT);

    n = 0;
    if (f_unused || f_deleted) begin
      n = 0;
    end else if (f_root) begin
      // The root wins even when the name is a double dot.
      chars[n++] = CHAR_SLASH;
    end else if (f_parent) begin
      chars[n++] = CHAR_DOT;
      chars[n++] = CHAR_DOT;
    end else begin
      first = 0;
      if (shadow_name[0] == CHAR_KANJI) begin
        chars[n++] = CHAR_DELETED;
        first = 1;
      end
      stop = 1'b0;
      for (int i = first; i < NAME_CHARS; i++) begin
        if (shadow_name[i] == CHAR_SPACE) stop = 1'b1;
        if (!stop) chars[n++] = shadow_name[i];
      end
      // Files get a dot even with a blank extension; subdirectories do not.
      if ((shadow_attr & ATTR_SUBDIR) == 8'h00) begin
        chars[n++] = CHAR_DOT;
        stop = 1'b0;
        for (int i = 0; i < EXT_CHARS; i++) begin
          if (shadow_name[NAME_CHARS + i] == CHAR_SPACE) stop = 1'b1;
          if (!stop) chars[n++] = shadow_name[NAME_CHARS + i];
        end
      end
    end

    x.attr    = shadow_attr;
    x.tm      = shadow_time;
    x.dt      = shadow_date;
    x.clus    = shadow_clus;
    x.fsize   = shadow_size;
    x.unused  = f_unused;
    x.deleted = f_deleted;
    x.root    = f_root;
    x.parent  = f_parent;
    if (n == 0) begin
      x.ch = 8'h00;
      x.present = 1'b0;
      x.last = 1'b1;
      expected_names.push_back(x);
    end else begin
      for (int i = 0; i < n; i++) begin
        x.ch = chars[i];
        x.present = 1'b1;
        x.last = (i == n - 1);
        expected_names.push_back(x);
      end
    end
    entries_done++;
  endtask

  // Sends one entry byte. Entered and left at a falling edge; in_tvalid is
  // left high so that a following byte can go out back to back.
  task automatic send_entry_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if ($urandom_range(99) < in_gap_pct) gap = draw_idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_entry_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_entry();
    for (int i = 0; i < ENTRY_BYTES; i++) send_entry_byte(entry_buf[i]);
  endtask

  // Fills entry_buf from an 11-byte name (first byte in the top bits) and the
  // fields; the reserved bytes 12 to 21 get random filler.
  task automatic build_entry(input logic [87:0] nm, input logic [7:0] attr,
                             input logic [15:0] tm, input logic [15:0] dt,
                             input logic [15:0] clus, input logic [31:0] fsize);
    for (int i = 0; i < NAME_BYTES; i++) entry_buf[i] = nm[87 - 8*i -: 8];
    for (int i = NAME_BYTES; i < ENTRY_BYTES; i++) entry_buf[i] = 8'($urandom_range(255));
    entry_buf[POS_ATTR]    = attr;
    entry_buf[POS_TIME_LO] = tm[7:0];
    entry_buf[POS_TIME_HI] = tm[15:8];
    entry_buf[POS_DATE_LO] = dt[7:0];
    entry_buf[POS_DATE_HI] = dt[15:8];
    entry_buf[POS_CLUS_LO] = clus[7:0];
    entry_buf[POS_CLUS_HI] = clus[15:8];
    entry_buf[POS_SIZE_0]  = fsize[7:0];
    entry_buf[POS_SIZE_1]  = fsize[15:8];
    entry_buf[POS_SIZE_2]  = fsize[23:16];
    entry_buf[POS_LAST]    = fsize[31:24];
  endtask

  function automatic logic [7:0] pick_name_char();
    if ($urandom_range(99) < 80) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(255));
  endfunction

  // Random entry: mostly well-formed 8.3 names with random content, mixed
  // with the special first bytes, and some entries of pure noise.
  task automatic randomize_entry();
    int kind, nlen, elen;
    for (int i = 0; i < ENTRY_BYTES; i++) entry_buf[i] = 8'($urandom_range(255));
    kind = $urandom_range(99);
    if (kind >= 12) begin
      nlen = $urandom_range(NAME_CHARS);
      elen = $urandom_range(EXT_CHARS);
      for (int i = 0; i < NAME_CHARS; i++)
        entry_buf[i] = (i < nlen) ? pick_name_char() : CHAR_SPACE;
      for (int i = 0; i < EXT_CHARS; i++)
        entry_buf[NAME_CHARS + i] = (i < elen) ? pick_name_char() : CHAR_SPACE;
      // Now and then put characters after a space; they must be dropped.
      if ($urandom_range(9) == 0 && nlen < NAME_CHARS - 1) entry_buf[nlen + 1] = "X";
      if ($urandom_range(9) == 0 && elen < EXT_CHARS - 1)
        entry_buf[NAME_CHARS + elen + 1] = "Y";
      if (kind < 20) entry_buf[0] = CHAR_NUL;
      else if (kind < 28) entry_buf[0] = CHAR_DELETED;
      else if (kind < 38) begin
        entry_buf[0] = CHAR_DOT;
        if ($urandom_range(1)) entry_buf[1] = CHAR_DOT;
        if ($urandom_range(1)) begin
          entry_buf[POS_CLUS_LO] = 8'h00;
          entry_buf[POS_CLUS_HI] = 8'h00;
        end
      end else if (kind < 46) entry_buf[0] = CHAR_KANJI;
      if ($urandom_range(7) == 0) begin
        entry_buf[POS_CLUS_LO] = 8'h00;
        entry_buf[POS_CLUS_HI] = 8'h00;
      end
      // Field extremes: all ones or all zeros across time, date and size.
      case ($urandom_range(9))
        0: for (int i = POS_TIME_LO; i < ENTRY_BYTES; i++)
             if (i != POS_CLUS_LO && i != POS_CLUS_HI) entry_buf[i] = 8'hFF;
        1: for (int i = POS_TIME_LO; i < ENTRY_BYTES; i++)
             if (i != POS_CLUS_LO && i != POS_CLUS_HI) entry_buf[i] = 8'h00;
        default: ;
      endcase
    end
  endtask

  // Output side: random stalls, plus the one-shot hold-off that a test may
  // request, counted here cycle by cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < out_stall_pct) begin
        out_tready <= 1'b0;
        stall_left = draw_idle_len() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // Every accepted output transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    name_xact_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_names.size() == 0) begin
        $error("unexpected output transaction: name_char 0x%0h", out_tdata[7:0]);
        mismatches++;
      end else begin
        want = expected_names.pop_front();
        check_field("name_char", 32'(want.ch), 32'(out_tdata[7:0]));
        check_field("name_present", 32'(want.present), 32'(out_tuser));
        check_field("last_char", 32'(want.last), 32'(out_tlast));
        check_field("attributes", 32'(want.attr), 32'(out_tdata[15:8]));
        check_field("time_raw", 32'(want.tm), 32'(out_tdata[31:16]));
        check_field("date_raw", 32'(want.dt), 32'(out_tdata[47:32]));
        check_field("start_cluster", 32'(want.clus), 32'(out_tdata[63:48]));
        check_field("file_size", want.fsize, out_tdata[95:64]);
        check_field("is_unused", 32'(want.unused), 32'(out_tdata[96]));
        check_field("is_deleted", 32'(want.deleted), 32'(out_tdata[97]));
        check_field("is_root", 32'(want.root), 32'(out_tdata[98]));
        check_field("is_parent", 32'(want.parent), 32'(out_tdata[99]));
        check_field("tdata padding", 32'h0, 32'(out_tdata[103:100]));
        xacts_checked++;
        if (!want.present) empty_checked++;
      end
    end
  end

  // Unused and deleted entries each give one empty transaction.
  task automatic test_reserved_entries();
    build_entry({CHAR_NUL, "OLDFILE", "TXT"}, 8'h20, 16'h1234, 16'h5678, 16'h0002, 32'd100);
    send_entry();
    build_entry({CHAR_DELETED, "OLDFILE", "TXT"}, 8'h01, 16'h0000, 16'hFFFF, 16'h0000, 32'd0);
    send_entry();
  endtask

  // Dot names: root, a plain dot with a nonzero cluster, the parent, and a
  // double dot with cluster zero, where the root rule wins.
  task automatic test_dot_entries();
    build_entry(".          ", ATTR_SUBDIR, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    send_entry();
    build_entry(".          ", ATTR_SUBDIR, 16'h4A21, 16'h5A9C, 16'h0005, 32'd0);
    send_entry();
    build_entry("..         ", ATTR_SUBDIR, 16'h8001, 16'h0021, 16'h0123, 32'd0);
    send_entry();
    build_entry("..         ", 8'h00, 16'h7FFF, 16'h8000, 16'h0000, 32'h8000_0000);
    send_entry();
  endtask

  // General naming rule: a leading 0x05 shown as 0xE5 with the name and the
  // extension both cut at a space, a blank extension with its trailing dot,
  // and a subdirectory whose blank name yields no characters at all.
  task automatic test_plain_names();
    build_entry({CHAR_KANJI, "B CD   ", "T X"}, 8'hEF, 16'hA5A5, 16'h5A5A, 16'hBEEF,
                32'h1234_5678);
    send_entry();
    build_entry("README     ", 8'h20, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
    send_entry();
    build_entry("           ", ATTR_SUBDIR, 16'hFFFF, 16'h0000, 16'h0009, 32'd9);
    send_entry();
  endtask

  // A couple of random entries, the first with no idling on either side and
  // the next with frequent gaps and stalls.
  task automatic test_random_entries();
    int start_bytes;
    int k;
    start_bytes = bytes_sent;
    k = 0;
    while (bytes_sent - start_bytes < 64) begin
      case (k % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 30; out_stall_pct = 30; end
        2: begin in_gap_pct = 5;  out_stall_pct = 60; end
        default: begin in_gap_pct = 50; out_stall_pct = 5; end
      endcase
      randomize_entry();
      send_entry();
      k++;
    end
    in_gap_pct = 20;
    out_stall_pct = 20;
  endtask

  // The receiver holds off for a long stretch while full-length names keep
  // arriving back to back, so the output register fills and the input
  // stalls. Afterwards everything must drain in order.
  task automatic test_backpressure();
    in_gap_pct = 0;
    out_stall_pct = 0;
    hold_cycles = 300;
    for (int e = 0; e < 2; e++) begin
      build_entry("LONGNAMEEXT", 8'h00, 16'hFFFF, 16'h0000, 16'(16'h1000 + e),
                  32'hDEAD_0000 + e);
      entry_buf[0] = 8'("A" + e);
      send_entry();
    end
    while (hold_cycles > 0) @(negedge clk);
    in_gap_pct = 20;
    out_stall_pct = 20;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reserved_entries();
    test_dot_entries();
    test_plain_names();
    test_random_entries();
    test_backpressure();
    in_tvalid <= 1'b0;

    // Wait for the last names to drain, then keep watching the output so
    // that any stray transaction would still be caught.
    while (expected_names.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Sent %0d entry bytes (%0d entries) with random gaps and stalls.",
             bytes_sent, entries_done);
    $display("Checked %0d name transactions, %0d of them empty names.",
             xacts_checked, empty_checked);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Safety net: the slowest legal run is far below this bound.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
